FILE: hw/rtl/mse_pkg.sv
`default_nettype none

package mse_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int IDX_W     = 10;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;
    localparam logic [5:0] OP_ADDIU = 6'b001000;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_J     = 6'b000010;

    localparam logic [5:0] FN_ADDU  = 6'b100000;
    localparam logic [5:0] FN_SUBU  = 6'b100010;
    localparam logic [5:0] FN_MULU  = 6'b011000;

    typedef enum logic [1:0] {
        FUNC_EXEC   = 2'd0,
        FUNC_MEM_WR = 2'd1,
        FUNC_MEM_RD = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // source of the register writeback value
    typedef enum logic [1:0] {
        RV_NONE,
        RV_ALU,
        RV_MUL,
        RV_LOAD
    } rval_sel_t;

    // source of the reported memory word
    typedef enum logic {
        MV_REG,
        MV_LOAD
    } mval_sel_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [MEM_AW-1:0] idx;
        logic [31:0]       wdata;
    } mem_req_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic [31:0] npc;
        logic        taken;
        rval_sel_t   rval_sel;
        logic [4:0]  ridx;
        logic [31:0] alu;
        logic [31:0] mul;
        mem_req_t    mem;
        mval_sel_t   mval_sel;
        logic [31:0] mval;
        logic        set_halt;
    } exec_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mse_regfile.sv
`default_nettype none

module mse_regfile
    import mse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        rd_en,
    input  wire logic [4:0]  rs_addr,
    input  wire logic [4:0]  rt_addr,
    input  wire rf_wr_t      wr,
    output logic      [31:0] rs_data,
    output logic      [31:0] rt_data
);

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] rs_q_reg;
    logic [31:0] rt_q_reg;
    logic        rs_v_reg;
    logic        rt_v_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.data;
        end
        if (rd_en) begin
            rs_q_reg <= mem[rs_addr];
            rt_q_reg <= mem[rt_addr];
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rs_v_reg  <= 1'b0;
            rt_v_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en) begin
                rs_v_reg <= valid_reg[rs_addr];
                rt_v_reg <= valid_reg[rt_addr];
            end
        end
    end

    assign rs_data = rs_v_reg ? rs_q_reg : '0;
    assign rt_data = rt_v_reg ? rt_q_reg : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/mse_dmem.sv
`default_nettype none

module mse_dmem
    import mse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire mem_req_t    req,
    output logic      [31:0] rdata,
    output logic             ready
);

    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_WORDS - 1);

    logic [31:0]       mem [MEM_WORDS];
    logic [31:0]       rdata_reg;
    logic [MEM_AW-1:0] clr_idx_reg;
    logic              clearing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_idx_reg == CLR_LAST) begin
                clearing_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + MEM_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (req.en) begin
            if (req.we) begin
                mem[req.idx] <= req.wdata;
            end else begin
                rdata_reg <= mem[req.idx];
            end
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clearing_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mse_exec.sv
`default_nettype none

module mse_exec
    import mse_pkg::*;
(
    input  wire func_t       func,
    input  wire logic [31:0] word,
    input  wire logic [9:0]  addr,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] pc,
    input  wire logic        halted,
    output exec_res_t        res
);

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [31:0] seq;
    logic [31:0] sum_ai;
    rval_sel_t   sel;
    logic [4:0]  dst;

    assign op     = word[31:26];
    assign fn     = word[5:0];
    assign rt     = word[20:16];
    assign rd     = word[15:11];
    assign imm    = {{16{word[15]}}, word[15:0]};
    assign seq    = pc + 32'd4;
    assign sum_ai = a + imm;

    always_comb begin
        res          = '0;
        res.npc      = pc;
        res.rval_sel = RV_NONE;
        res.mval_sel = MV_REG;
        res.mul      = a * b;
        sel          = RV_NONE;
        dst          = '0;
        unique case (func)
            FUNC_MEM_WR: begin
                res.mem.en    = 1'b1;
                res.mem.we    = 1'b1;
                res.mem.idx   = MEM_AW'(addr);
                res.mem.wdata = word;
                res.mval      = word;
            end
            FUNC_MEM_RD: begin
                res.mem.en   = 1'b1;
                res.mem.idx  = MEM_AW'(addr);
                res.mval_sel = MV_LOAD;
            end
            FUNC_EXEC: begin
                if (!halted) begin
                    if (word == HALT_WORD) begin
                        res.set_halt = 1'b1;
                    end else begin
                        res.npc = seq;
                        unique case (op)
                            OP_RTYPE: begin
                                dst = rd;
                                if (fn == FN_ADDU) begin
                                    sel     = RV_ALU;
                                    res.alu = a + b;
                                end else if (fn == FN_SUBU) begin
                                    sel     = RV_ALU;
                                    res.alu = a - b;
                                end else if (fn == FN_MULU) begin
                                    sel = RV_MUL;
                                end
                            end
                            OP_ADDIU: begin
                                sel     = RV_ALU;
                                dst     = rt;
                                res.alu = sum_ai;
                            end
                            OP_LW: begin
                                sel          = RV_LOAD;
                                dst          = rt;
                                res.mem.en   = 1'b1;
                                res.mem.idx  = MEM_AW'(sum_ai);
                                res.mval_sel = MV_LOAD;
                            end
                            OP_SW: begin
                                res.mem.en    = 1'b1;
                                res.mem.we    = 1'b1;
                                res.mem.idx   = MEM_AW'(sum_ai);
                                res.mem.wdata = b;
                                res.mval      = b;
                            end
                            OP_BEQ: begin
                                if (a == b) begin
                                    res.taken = 1'b1;
                                    res.npc   = seq + {imm[29:0], 2'b00};
                                end
                            end
                            OP_J: begin
                                res.taken = 1'b1;
                                res.npc   = {seq[31:28], word[25:0], 2'b00};
                            end
                            default: ;
                        endcase
                        // drop writes to register zero
                        if (sel != RV_NONE && dst != 5'd0) begin
                            res.rval_sel = sel;
                            res.ridx     = dst;
                        end
                    end
                end
            end
            FUNC_NONE: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mips_subset_execution_core.sv
`default_nettype none

// Stages: an item is registered in the read stage, then in the writeback / output stage,
// where its result is valid and holds while m_ready is low. Throughput: one item per cycle
// unless m_ready is low or the data memory is clearing; register results are forwarded from
// the writeback stage and the last write, and every data memory access uses its one port.
// Reset: program counter, halt flag and register file valid bits clear at once; the data
// memory is then swept to zero, one word a cycle, all 1024 words with s_ready low.
module mips_subset_execution_core
    import mse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [31:0] s_word,
    input  wire logic [9:0]  s_addr,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_pc_of_item,
    output logic      [31:0] m_next_pc,
    output logic             m_branch_taken,
    output logic             m_reg_we,
    output logic      [4:0]  m_reg_index,
    output logic      [31:0] m_reg_value,
    output logic             m_mem_we,
    output logic      [9:0]  m_mem_index,
    output logic      [31:0] m_mem_value,
    output logic             m_halted
);

    logic        dmem_ready;
    logic [31:0] dmem_rdata;
    mem_req_t    dmem_req;
    rf_wr_t      rf_wr;
    logic [31:0] rf_rs_data;
    logic [31:0] rf_rt_data;
    exec_res_t   ex;

    // architectural state outside the memories
    logic [31:0] pc_reg;
    logic        halt_reg;

    // read stage
    logic        s1_valid_reg;
    func_t       s1_func_reg;
    logic [31:0] s1_word_reg;
    logic [9:0]  s1_addr_reg;

    // writeback / output stage
    logic              s2_valid_reg;
    logic [31:0]       s2_pc_reg;
    logic [31:0]       s2_npc_reg;
    logic              s2_taken_reg;
    rval_sel_t         s2_rsel_reg;
    logic [4:0]        s2_ridx_reg;
    logic [31:0]       s2_alu_reg;
    logic [31:0]       s2_mul_reg;
    logic              s2_mwe_reg;
    logic [MEM_AW-1:0] s2_midx_reg;
    mval_sel_t         s2_msel_reg;
    logic [31:0]       s2_mval_reg;
    logic              s2_halted_reg;

    // last register write, for items that read the file in the same cycle
    logic        wb_en_reg;
    logic [4:0]  wb_idx_reg;
    logic [31:0] wb_val_reg;

    logic        s2_load;
    logic        s1_adv;
    logic        accept;
    logic [31:0] s2_rval;
    logic [4:0]  s1_rs;
    logic [4:0]  s1_rt;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        s2_fwd_ok;

    assign s2_load = !s2_valid_reg || m_ready;
    assign s1_adv  = s1_valid_reg && s2_load;
    assign s_ready = dmem_ready && (!s1_valid_reg || s2_load);
    assign accept  = s_valid && s_ready;

    always_comb begin
        unique case (s2_rsel_reg)
            RV_NONE: s2_rval = '0;
            RV_ALU:  s2_rval = s2_alu_reg;
            RV_MUL:  s2_rval = s2_mul_reg;
            RV_LOAD: s2_rval = dmem_rdata;
        endcase
    end

    assign s1_rs     = s1_word_reg[25:21];
    assign s1_rt     = s1_word_reg[20:16];
    assign s2_fwd_ok = s2_valid_reg && (s2_rsel_reg != RV_NONE);

    // newest value first: pending writeback, then last write, then the file
    always_comb begin
        priority if (s2_fwd_ok && s2_ridx_reg == s1_rs) begin
            op_a = s2_rval;
        end else if (wb_en_reg && wb_idx_reg == s1_rs) begin
            op_a = wb_val_reg;
        end else begin
            op_a = rf_rs_data;
        end
        priority if (s2_fwd_ok && s2_ridx_reg == s1_rt) begin
            op_b = s2_rval;
        end else if (wb_en_reg && wb_idx_reg == s1_rt) begin
            op_b = wb_val_reg;
        end else begin
            op_b = rf_rt_data;
        end
    end

    assign rf_wr.en   = s2_valid_reg && m_ready && (s2_rsel_reg != RV_NONE);
    assign rf_wr.idx  = s2_ridx_reg;
    assign rf_wr.data = s2_rval;

    mse_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rs_addr (s_word[25:21]),
        .rt_addr (s_word[20:16]),
        .wr      (rf_wr),
        .rs_data (rf_rs_data),
        .rt_data (rf_rt_data)
    );

    mse_exec u_exec (
        .func   (s1_func_reg),
        .word   (s1_word_reg),
        .addr   (s1_addr_reg),
        .a      (op_a),
        .b      (op_b),
        .pc     (pc_reg),
        .halted (halt_reg),
        .res    (ex)
    );

    always_comb begin
        dmem_req    = ex.mem;
        dmem_req.en = ex.mem.en && s1_adv;
    end

    mse_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dmem_req),
        .rdata   (dmem_rdata),
        .ready   (dmem_ready)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wb_en_reg    <= 1'b0;
        end else begin
            if (!s1_valid_reg || s2_load) begin
                s1_valid_reg <= accept;
            end
            if (s2_load) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_adv) begin
                pc_reg   <= ex.npc;
                halt_reg <= halt_reg || ex.set_halt;
            end
            if (rf_wr.en) begin
                wb_en_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_func_reg <= func_t'(s_func);
            s1_word_reg <= s_word;
            s1_addr_reg <= s_addr;
        end
        if (s1_adv) begin
            s2_pc_reg     <= pc_reg;
            s2_npc_reg    <= ex.npc;
            s2_taken_reg  <= ex.taken;
            s2_rsel_reg   <= ex.rval_sel;
            s2_ridx_reg   <= ex.ridx;
            s2_alu_reg    <= ex.alu;
            s2_mul_reg    <= ex.mul;
            s2_mwe_reg    <= ex.mem.we;
            s2_midx_reg   <= ex.mem.idx;
            s2_msel_reg   <= ex.mval_sel;
            s2_mval_reg   <= ex.mval;
            s2_halted_reg <= halt_reg || ex.set_halt;
        end
        if (rf_wr.en) begin
            wb_idx_reg <= rf_wr.idx;
            wb_val_reg <= rf_wr.data;
        end
    end

    assign m_valid        = s2_valid_reg;
    assign m_pc_of_item   = s2_pc_reg;
    assign m_next_pc      = s2_npc_reg;
    assign m_branch_taken = s2_taken_reg;
    assign m_reg_we       = (s2_rsel_reg != RV_NONE);
    assign m_reg_index    = s2_ridx_reg;
    assign m_reg_value    = s2_rval;
    assign m_mem_we       = s2_mwe_reg;
    assign m_mem_index    = IDX_W'(s2_midx_reg);
    assign m_mem_value    = (s2_msel_reg == MV_LOAD) ? dmem_rdata : s2_mval_reg;
    assign m_halted       = s2_halted_reg;

endmodule

`default_nettype wire
